/* rtl/char_lcd_write_sequencer_macros.svh */
// Assertion helpers shared by the sequencer modules.
// Each expects signals named clk and arst_n in the module that uses it.
`ifndef CHAR_LCD_WRITE_SEQUENCER_MACROS_SVH
`define CHAR_LCD_WRITE_SEQUENCER_MACROS_SVH

// A property checked at every clock edge outside reset.
`define CLWS_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// When the antecedent holds, the consequent holds in the next cycle.
`define CLWS_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

/* rtl/clws_pkg.sv */
package clws_pkg;

	localparam int DEF_MAX_COLUMNS = 40;
	localparam int DEF_QUEUE_DEPTH = 4;

	localparam logic [7:0] CMD_CLEAR = 8'h01;

	localparam logic [4:0] HOLD_NONE = 5'd0;
	localparam logic [4:0] HOLD_RS   = 5'd1;
	localparam logic [4:0] HOLD_EN   = 5'd2;
	localparam logic [4:0] HOLD_WAIT = 5'd20;

	// Configuration register indexes.
	typedef enum logic [2:0] {
		REG_FOUR_BIT_MODE,
		REG_COLUMN_COUNT,
		REG_ROW_COUNT,
		REG_FUNCTION_SET_EIGHT_BIT,
		REG_FUNCTION_SET_FOUR_BIT,
		REG_FOUR_BIT_INIT_ONE,
		REG_FOUR_BIT_INIT_TWO,
		REG_DISPLAY_ON_CURSOR_OFF
	} reg_index_t;

	typedef struct packed {
		logic       four_bit_mode;
		logic [5:0] column_count;
		logic [2:0] row_count;
		logic [7:0] function_set_eight_bit;
		logic [7:0] function_set_four_bit;
		logic [7:0] four_bit_init_one;
		logic [7:0] four_bit_init_two;
		logic [7:0] display_on_cursor_off;
	} cfg_t;

	typedef enum logic [1:0] {
		JOB_BYTE,
		JOB_WAIT,
		JOB_ERROR
	} job_kind_t;

	// One unit of work for the pin sequencer: a byte transfer, the power-on
	// wait or the bad-row marker.
	typedef struct packed {
		job_kind_t  kind;
		logic       rs;
		logic [7:0] data;
		logic       last;
	} job_t;

	// DDRAM address of column zero on each display row.
	function automatic logic [7:0] row_base(input logic [1:0] r);
		logic [7:0] base;
		case (r)
			2'd0:    base = 8'h80;
			2'd1:    base = 8'hC0;
			2'd2:    base = 8'h94;
			default: base = 8'hD4;
		endcase
		return base;
	endfunction

endpackage

/* rtl/clws_front.sv */
`include "char_lcd_write_sequencer_macros.svh"

module clws_front #(
	parameter int MAX_COLUMNS = clws_pkg::DEF_MAX_COLUMNS
) (
	input  logic              clk,
	input  logic              arst_n,
	input  clws_pkg::cfg_t    cfg,
	input  logic              push,
	output logic              full,
	input  logic [1:0]        func,
	input  logic [7:0]        data_byte,
	input  logic [2:0]        row,
	input  logic [5:0]        col,
	output logic              job_valid,
	output clws_pkg::job_t    job,
	input  logic              job_full
);
	import clws_pkg::*;

	typedef enum logic [2:0] {
		OP_INIT,
		OP_CMD,
		OP_CHAR,
		OP_MOVE,
		OP_BADROW
	} op_t;

	localparam logic [1:0] FUNC_INIT = 2'd0;
	localparam logic [1:0] FUNC_CMD  = 2'd1;
	localparam logic [1:0] FUNC_CHAR = 2'd2;

	logic       valid_s1;
	op_t        op_s1;
	logic [7:0] byte_s1;
	logic [7:0] addr_s1;
	logic       wrap_s1;
	logic [2:0] idx_q;
	logic [1:0] cur_row_q;
	logic [5:0] cur_col_q;

	logic [5:0] cols_eff;
	logic [2:0] rows_eff;
	logic [6:0] col_inc;
	logic [2:0] row_inc;
	logic [1:0] row_next;
	logic       col_wrap;
	logic       accept;
	logic       emit;
	logic       done;

	always_comb begin
		if (cfg.column_count == 6'd0) begin
			cols_eff = 6'd1;
		end else if (cfg.column_count > 6'(MAX_COLUMNS)) begin
			cols_eff = 6'(MAX_COLUMNS);
		end else begin
			cols_eff = cfg.column_count;
		end
		if (cfg.row_count == 3'd0) begin
			rows_eff = 3'd1;
		end else if (cfg.row_count > 3'd4) begin
			rows_eff = 3'd4;
		end else begin
			rows_eff = cfg.row_count;
		end
	end

	// A move may leave the cursor past the column count, so the compare is >=.
	assign col_inc  = {1'b0, cur_col_q} + 7'd1;
	assign col_wrap = col_inc >= {1'b0, cols_eff};
	assign row_inc  = {1'b0, cur_row_q} + 3'd1;
	assign row_next = (row_inc >= rows_eff) ? 2'd0 : row_inc[1:0];

	// Pick the job for the current index of the held item.
	always_comb begin
		job.kind = JOB_BYTE;
		job.rs   = 1'b0;
		job.data = byte_s1;
		job.last = 1'b1;
		case (op_s1)
			OP_INIT: begin
				if (cfg.four_bit_mode) begin
					job.last = idx_q == 3'd5;
					case (idx_q)
						3'd0:    job.kind = JOB_WAIT;
						3'd1:    job.data = cfg.function_set_four_bit;
						3'd2:    job.data = cfg.four_bit_init_one;
						3'd3:    job.data = cfg.four_bit_init_two;
						3'd4:    job.data = cfg.display_on_cursor_off;
						default: job.data = CMD_CLEAR;
					endcase
				end else begin
					job.last = idx_q == 3'd3;
					case (idx_q)
						3'd0:    job.kind = JOB_WAIT;
						3'd1:    job.data = cfg.function_set_eight_bit;
						3'd2:    job.data = cfg.display_on_cursor_off;
						default: job.data = CMD_CLEAR;
					endcase
				end
			end
			OP_CMD: begin
			end
			OP_CHAR: begin
				if (idx_q == 3'd0) begin
					job.rs   = 1'b1;
					job.last = !wrap_s1;
				end else begin
					job.data = addr_s1;
				end
			end
			OP_MOVE: begin
				job.data = addr_s1;
			end
			default: begin
				job.kind = JOB_ERROR;
			end
		endcase
	end

	assign job_valid = valid_s1;
	assign emit      = valid_s1 && !job_full;
	assign done      = emit && job.last;
	assign full      = valid_s1 && !done;
	assign accept    = push && !full;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1  <= 1'b0;
			op_s1     <= OP_CMD;
			byte_s1   <= '0;
			addr_s1   <= '0;
			wrap_s1   <= 1'b0;
			idx_q     <= '0;
			cur_row_q <= '0;
			cur_col_q <= '0;
		end else begin
			if (emit) begin
				idx_q <= idx_q + 3'd1;
				if (done) begin
					valid_s1 <= 1'b0;
				end
			end
			// The cursor moves when the item is taken; its jobs follow later.
			if (accept) begin
				valid_s1 <= 1'b1;
				idx_q    <= '0;
				byte_s1  <= data_byte;
				wrap_s1  <= 1'b0;
				case (func)
					FUNC_INIT: begin
						op_s1     <= OP_INIT;
						cur_row_q <= '0;
						cur_col_q <= '0;
					end
					FUNC_CMD: begin
						op_s1 <= OP_CMD;
					end
					FUNC_CHAR: begin
						op_s1   <= OP_CHAR;
						wrap_s1 <= col_wrap;
						addr_s1 <= row_base(row_next);
						if (col_wrap) begin
							cur_row_q <= row_next;
							cur_col_q <= '0;
						end else begin
							cur_col_q <= col_inc[5:0];
						end
					end
					default: begin
						if (row[2]) begin
							op_s1 <= OP_BADROW;
						end else begin
							op_s1     <= OP_MOVE;
							addr_s1   <= row_base(row[1:0]) + {2'b00, col};
							cur_row_q <= row[1:0];
							cur_col_q <= col;
						end
					end
				endcase
			end
		end
	end

	`CLWS_ASSERT_NEXT(a_front_load, accept, valid_s1 && idx_q == 3'd0, "front: item not loaded")
	`CLWS_ASSERT(a_front_short, valid_s1 && op_s1 != OP_INIT |-> idx_q <= 3'd1, "front: job overrun")

endmodule

/* rtl/clws_job_queue.sv */
`include "char_lcd_write_sequencer_macros.svh"

module clws_job_queue #(
	parameter int DEPTH = clws_pkg::DEF_QUEUE_DEPTH
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           wr_en,
	input  clws_pkg::job_t wr_data,
	output logic           q_full,
	input  logic           rd_en,
	output clws_pkg::job_t rd_data,
	output logic           q_empty
);
	import clws_pkg::*;

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);

	job_t             mem_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;
	logic             do_wr;
	logic             do_rd;

	assign q_full  = count_q == CNT_W'(DEPTH);
	assign q_empty = count_q == '0;
	assign do_wr   = wr_en && !q_full;
	assign do_rd   = rd_en && !q_empty;
	assign rd_data = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (do_wr) begin
			mem_q[wr_ptr_q] <= wr_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_wr) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + PTR_W'(1);
			end
			if (do_rd) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + PTR_W'(1);
			end
			if (do_wr && !do_rd) begin
				count_q <= count_q + CNT_W'(1);
			end else if (do_rd && !do_wr) begin
				count_q <= count_q - CNT_W'(1);
			end
		end
	end

	`CLWS_ASSERT(a_queue_count, count_q <= CNT_W'(DEPTH), "queue: count past depth")

endmodule

/* rtl/clws_back.sv */
`include "char_lcd_write_sequencer_macros.svh"

module clws_back (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           four_bit_mode,
	input  clws_pkg::job_t q_data,
	input  logic           q_empty,
	output logic           q_pop,
	output logic           empty,
	input  logic           pop,
	output logic           rs,
	output logic           enable,
	output logic [7:0]     data_pins,
	output logic [4:0]     hold_ms,
	output logic           error,
	output logic           last
);
	import clws_pkg::*;

	logic       active_q;
	job_t       job_q;
	logic [2:0] step_q;
	logic       out_valid_q;
	logic       rs_q;
	logic       en_q;
	logic [7:0] data_q;
	logic [4:0] hold_q;
	logic       err_q;
	logic       last_q;

	logic       adv;
	logic       fire;
	logic       final_step;
	logic       take;
	logic       ev_rs;
	logic       ev_en;
	logic [7:0] ev_data;
	logic [4:0] ev_hold;
	logic       ev_err;

	assign adv  = !out_valid_q || pop;
	assign fire = active_q && adv;

	always_comb begin
		if (job_q.kind != JOB_BYTE) begin
			final_step = 1'b1;
		end else if (four_bit_mode) begin
			final_step = step_q == 3'd6;
		end else begin
			final_step = step_q == 3'd3;
		end
	end

	// The next job is loaded in the same cycle as the last beat of the current one.
	assign take  = !q_empty && (!active_q || (fire && final_step));
	assign q_pop = take;

	// Pins change one at a time; every event starts from the levels now on the pins.
	always_comb begin
		ev_rs   = rs_q;
		ev_en   = en_q;
		ev_data = data_q;
		ev_hold = HOLD_EN;
		ev_err  = 1'b0;
		case (job_q.kind)
			JOB_BYTE: begin
				if (four_bit_mode) begin
					case (step_q)
						3'd0: begin
							ev_rs   = job_q.rs;
							ev_hold = HOLD_RS;
						end
						3'd1:    ev_en   = 1'b1;
						3'd2:    ev_data = {job_q.data[7:4], 4'h0};
						3'd3:    ev_en   = 1'b0;
						3'd4:    ev_en   = 1'b1;
						3'd5:    ev_data = {job_q.data[3:0], 4'h0};
						default: ev_en   = 1'b0;
					endcase
				end else begin
					case (step_q)
						3'd0: begin
							ev_rs   = job_q.rs;
							ev_hold = HOLD_RS;
						end
						3'd1:    ev_en   = 1'b1;
						3'd2:    ev_data = job_q.data;
						default: ev_en   = 1'b0;
					endcase
				end
			end
			JOB_WAIT: begin
				ev_hold = HOLD_WAIT;
			end
			default: begin
				ev_hold = HOLD_NONE;
				ev_err  = 1'b1;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q    <= 1'b0;
			job_q       <= '0;
			step_q      <= '0;
			out_valid_q <= 1'b0;
			rs_q        <= 1'b0;
			en_q        <= 1'b0;
			data_q      <= '0;
			hold_q      <= '0;
			err_q       <= 1'b0;
			last_q      <= 1'b0;
		end else begin
			if (fire) begin
				out_valid_q <= 1'b1;
				rs_q        <= ev_rs;
				en_q        <= ev_en;
				data_q      <= ev_data;
				hold_q      <= ev_hold;
				err_q       <= ev_err;
				last_q      <= job_q.last && final_step;
				if (final_step) begin
					step_q   <= '0;
					active_q <= 1'b0;
				end else begin
					step_q <= step_q + 3'd1;
				end
			end else if (pop) begin
				out_valid_q <= 1'b0;
			end
			if (take) begin
				active_q <= 1'b1;
				job_q    <= q_data;
				step_q   <= '0;
			end
		end
	end

	assign empty     = !out_valid_q;
	assign rs        = rs_q;
	assign enable    = en_q;
	assign data_pins = data_q;
	assign hold_ms   = hold_q;
	assign error     = err_q;
	assign last      = last_q;

	`CLWS_ASSERT(a_back_single, active_q && job_q.kind != JOB_BYTE |-> step_q == 3'd0, "back: bad step")
	`CLWS_ASSERT_NEXT(a_back_strobe, fire && final_step && job_q.kind == JOB_BYTE, !en_q, "back: strobe left high")

endmodule

/* rtl/char_lcd_write_sequencer.sv */
// Character-LCD write sequencer: turns operation requests into pin events.
// Input side is a queue: push an item (func, data_byte, row, col) when full is low.
// func selects init, send command, write character or move cursor.
// Result side is a queue too: while empty is low the oldest pin event is on
// rs, enable, data_pins, hold_ms, error and last; pop takes it. last marks the
// final event of each item.
// Configuration registers are written through cfg_we, cfg_index and cfg_data; the user
// must write them only while no item is in flight, as the block does not enforce it.
// With the block idle, a taken item passes the front stage register, the job queue
// and the job register of the pin sequencer before its first event is registered out.
// Throughput: one event per cycle while pop stays high and the job queue is not
// empty; an item has 1 to 36 events (a 4-bit init is the longest). The front
// stage hands one job per cycle to the job queue while it has room and takes
// the next item in the cycle its last job goes in, so one-job items follow every
// cycle while the queue has room.
// When pop is held low, the output register holds its beat, the pin sequencer
// stops, the job queue fills and then full goes high.
// Reset clears the cursor to row 0, column 0, the pin levels to zero, empties
// all queues and loads the register defaults; no clearing pass follows.
module char_lcd_write_sequencer #(
	parameter int MAX_COLUMNS = clws_pkg::DEF_MAX_COLUMNS,
	parameter int QUEUE_DEPTH = clws_pkg::DEF_QUEUE_DEPTH
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       cfg_we,
	input  logic [2:0] cfg_index,
	input  logic [7:0] cfg_data,
	input  logic       push,
	output logic       full,
	input  logic [1:0] func,
	input  logic [7:0] data_byte,
	input  logic [2:0] row,
	input  logic [5:0] col,
	output logic       empty,
	input  logic       pop,
	output logic       rs,
	output logic       enable,
	output logic [7:0] data_pins,
	output logic [4:0] hold_ms,
	output logic       error,
	output logic       last
);
	import clws_pkg::*;

	cfg_t cfg_q;
	logic job_valid;
	job_t job;
	logic job_full;
	job_t q_data;
	logic q_empty;
	logic q_pop;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.four_bit_mode          <= 1'b1;
			cfg_q.column_count           <= 6'd16;
			cfg_q.row_count              <= 3'd2;
			cfg_q.function_set_eight_bit <= 8'h38;
			cfg_q.function_set_four_bit  <= 8'h28;
			cfg_q.four_bit_init_one      <= 8'h33;
			cfg_q.four_bit_init_two      <= 8'h32;
			cfg_q.display_on_cursor_off  <= 8'h0C;
		end else if (cfg_we) begin
			case (reg_index_t'(cfg_index))
				REG_FOUR_BIT_MODE:          cfg_q.four_bit_mode          <= cfg_data[0];
				REG_COLUMN_COUNT:           cfg_q.column_count           <= cfg_data[5:0];
				REG_ROW_COUNT:              cfg_q.row_count              <= cfg_data[2:0];
				REG_FUNCTION_SET_EIGHT_BIT: cfg_q.function_set_eight_bit <= cfg_data;
				REG_FUNCTION_SET_FOUR_BIT:  cfg_q.function_set_four_bit  <= cfg_data;
				REG_FOUR_BIT_INIT_ONE:      cfg_q.four_bit_init_one      <= cfg_data;
				REG_FOUR_BIT_INIT_TWO:      cfg_q.four_bit_init_two      <= cfg_data;
				REG_DISPLAY_ON_CURSOR_OFF:  cfg_q.display_on_cursor_off  <= cfg_data;
				default: begin
				end
			endcase
		end
	end

	clws_front #(
		.MAX_COLUMNS(MAX_COLUMNS)
	) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg_q),
		.push      (push),
		.full      (full),
		.func      (func),
		.data_byte (data_byte),
		.row       (row),
		.col       (col),
		.job_valid (job_valid),
		.job       (job),
		.job_full  (job_full)
	);

	clws_job_queue #(
		.DEPTH(QUEUE_DEPTH)
	) u_queue (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr_en   (job_valid),
		.wr_data (job),
		.q_full  (job_full),
		.rd_en   (q_pop),
		.rd_data (q_data),
		.q_empty (q_empty)
	);

	clws_back u_back (
		.clk           (clk),
		.arst_n        (arst_n),
		.four_bit_mode (cfg_q.four_bit_mode),
		.q_data        (q_data),
		.q_empty       (q_empty),
		.q_pop         (q_pop),
		.empty         (empty),
		.pop           (pop),
		.rs            (rs),
		.enable        (enable),
		.data_pins     (data_pins),
		.hold_ms       (hold_ms),
		.error         (error),
		.last          (last)
	);

endmodule

/* tb/char_lcd_write_sequencer_tb.sv */
`timescale 1ns / 100ps

module char_lcd_write_sequencer_tb;
	import clws_pkg::*;

	localparam int STALL_LIMIT = 4000;
	localparam int LONG_HOLD   = 400;
	localparam int ROW_LIMIT   = 4;
	localparam int MAX_REPORTS = 10;

	localparam logic [7:0] LINE0_ADDR = 8'h80;
	localparam logic [7:0] LINE1_ADDR = 8'hC0;
	localparam logic [7:0] LINE2_ADDR = 8'h94;
	localparam logic [7:0] LINE3_ADDR = 8'hD4;

	typedef enum logic [1:0] {
		OP_INIT,
		OP_COMMAND,
		OP_CHAR,
		OP_MOVE
	} op_t;

	typedef struct packed {
		op_t        op;
		logic [7:0] data;
		logic [2:0] row;
		logic [5:0] col;
	} lcd_item_t;

	typedef struct packed {
		logic       rs;
		logic       en;
		logic [7:0] data;
		logic [4:0] hold;
		logic       err;
		logic       last;
	} lcd_event_t;

	logic        clk;
	logic        arst_n    = 1'b0;
	logic        cfg_we    = 1'b0;
	reg_index_t  cfg_index = REG_FOUR_BIT_MODE;
	logic [7:0]  cfg_data  = 8'h00;
	logic        push      = 1'b0;
	logic        full;
	logic [1:0]  func      = 2'b00;
	logic [7:0]  data_byte = 8'h00;
	logic [2:0]  row       = 3'b000;
	logic [5:0]  col       = 6'b000000;
	logic        empty;
	logic        pop       = 1'b0;
	logic        rs;
	logic        enable;
	logic [7:0]  data_pins;
	logic [4:0]  hold_ms;
	logic        error;
	logic        last;

	char_lcd_write_sequencer i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.push      (push),
		.full      (full),
		.func      (func),
		.data_byte (data_byte),
		.row       (row),
		.col       (col),
		.empty     (empty),
		.pop       (pop),
		.rs        (rs),
		.enable    (enable),
		.data_pins (data_pins),
		.hold_ms   (hold_ms),
		.error     (error),
		.last      (last)
	);

	lcd_item_t  pending_items[$];
	lcd_event_t expected_events[$];

	cfg_t       pred_cfg;
	logic [1:0] cur_row;
	logic [5:0] cur_col;
	logic       pin_rs;
	logic       pin_en;
	logic [7:0] pin_data;

	logic       in_beat = 1'b0;
	int         fail_count = 0;
	int         idle_cycles = 0;
	int         hold_requests = 0;
	int         hold_served = 0;
	int         hold_left = 0;
	int         rx_tick = 0;
	int         burst_left = 0;
	int         gap_left = 0;
	int         gen_cols = 16;

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	// ---------------------------------------------------------------
	// Expected pin events
	// ---------------------------------------------------------------
	task automatic reset_predictor();
		pred_cfg.four_bit_mode          = 1'b1;
		pred_cfg.column_count           = 6'd16;
		pred_cfg.row_count              = 3'd2;
		pred_cfg.function_set_eight_bit = 8'h38;
		pred_cfg.function_set_four_bit  = 8'h28;
		pred_cfg.four_bit_init_one      = 8'h33;
		pred_cfg.four_bit_init_two      = 8'h32;
		pred_cfg.display_on_cursor_off  = 8'h0C;
		cur_row  = '0;
		cur_col  = '0;
		pin_rs   = 1'b0;
		pin_en   = 1'b0;
		pin_data = '0;
	endtask

	task automatic log_event(input logic [4:0] hold, input logic err);
		lcd_event_t ev;
		ev.rs   = pin_rs;
		ev.en   = pin_en;
		ev.data = pin_data;
		ev.hold = hold;
		ev.err  = err;
		ev.last = 1'b0;
		expected_events.push_back(ev);
	endtask

	task automatic expect_byte(input logic is_data, input logic [7:0] b);
		pin_rs = is_data;
		log_event(HOLD_RS, 1'b0);
		pin_en = 1'b1;
		log_event(HOLD_EN, 1'b0);
		if (pred_cfg.four_bit_mode) begin
			pin_data = {b[7:4], 4'h0};
			log_event(HOLD_EN, 1'b0);
			pin_en = 1'b0;
			log_event(HOLD_EN, 1'b0);
			pin_en = 1'b1;
			log_event(HOLD_EN, 1'b0);
			pin_data = {b[3:0], 4'h0};
			log_event(HOLD_EN, 1'b0);
			pin_en = 1'b0;
			log_event(HOLD_EN, 1'b0);
		end else begin
			pin_data = b;
			log_event(HOLD_EN, 1'b0);
			pin_en = 1'b0;
			log_event(HOLD_EN, 1'b0);
		end
	endtask

	task automatic expect_address(input logic [1:0] r, input logic [5:0] c);
		logic [7:0] line_start;
		case (r)
			2'd0:    line_start = LINE0_ADDR;
			2'd1:    line_start = LINE1_ADDR;
			2'd2:    line_start = LINE2_ADDR;
			default: line_start = LINE3_ADDR;
		endcase
		expect_byte(1'b0, line_start + {2'b00, c});
	endtask

	task automatic predict_item(input lcd_item_t it);
		int         ncols;
		int         nrows;
		int         next_col;
		int         next_row;
		lcd_event_t tail;
		ncols = pred_cfg.column_count;
		nrows = pred_cfg.row_count;
		if (ncols < 1) ncols = 1;
		if (ncols > DEF_MAX_COLUMNS) ncols = DEF_MAX_COLUMNS;
		if (nrows < 1) nrows = 1;
		if (nrows > ROW_LIMIT) nrows = ROW_LIMIT;
		case (it.op)
			OP_INIT: begin
				// Power-on wait leaves the pins where they are.
				log_event(HOLD_WAIT, 1'b0);
				if (pred_cfg.four_bit_mode) begin
					expect_byte(1'b0, pred_cfg.function_set_four_bit);
					expect_byte(1'b0, pred_cfg.four_bit_init_one);
					expect_byte(1'b0, pred_cfg.four_bit_init_two);
				end else begin
					expect_byte(1'b0, pred_cfg.function_set_eight_bit);
				end
				expect_byte(1'b0, pred_cfg.display_on_cursor_off);
				expect_byte(1'b0, CMD_CLEAR);
				cur_row = '0;
				cur_col = '0;
			end
			OP_COMMAND: begin
				expect_byte(1'b0, it.data);
			end
			OP_CHAR: begin
				next_col = int'(cur_col) + 1;
				expect_byte(1'b1, it.data);
				// A cursor parked beyond the column count wraps on the next write.
				if (next_col >= ncols) begin
					next_row = int'(cur_row) + 1;
					if (next_row >= nrows) next_row = 0;
					cur_row = next_row[1:0];
					cur_col = '0;
					expect_address(cur_row, 6'd0);
				end else begin
					cur_col = next_col[5:0];
				end
			end
			OP_MOVE: begin
				if (int'(it.row) >= ROW_LIMIT) begin
					log_event(HOLD_NONE, 1'b1);
				end else begin
					expect_address(it.row[1:0], it.col);
					cur_row = it.row[1:0];
					cur_col = it.col;
				end
			end
			default: begin
			end
		endcase
		tail = expected_events.pop_back();
		tail.last = 1'b1;
		expected_events.push_back(tail);
	endtask

	// ---------------------------------------------------------------
	// Monitor: configuration, accepted items, result check, watchdog
	// ---------------------------------------------------------------
	always @(posedge clk) begin : check_events
		lcd_item_t  taken;
		lcd_event_t seen;
		lcd_event_t want;
		if (!arst_n) begin
			reset_predictor();
			in_beat <= 1'b0;
			idle_cycles = 0;
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					REG_FOUR_BIT_MODE:          pred_cfg.four_bit_mode = cfg_data[0];
					REG_COLUMN_COUNT:           pred_cfg.column_count = cfg_data[5:0];
					REG_ROW_COUNT:              pred_cfg.row_count = cfg_data[2:0];
					REG_FUNCTION_SET_EIGHT_BIT: pred_cfg.function_set_eight_bit = cfg_data;
					REG_FUNCTION_SET_FOUR_BIT:  pred_cfg.function_set_four_bit = cfg_data;
					REG_FOUR_BIT_INIT_ONE:      pred_cfg.four_bit_init_one = cfg_data;
					REG_FOUR_BIT_INIT_TWO:      pred_cfg.four_bit_init_two = cfg_data;
					REG_DISPLAY_ON_CURSOR_OFF:  pred_cfg.display_on_cursor_off = cfg_data;
					default: ;
				endcase
			end
			if (push && !full) begin
				taken.op   = op_t'(func);
				taken.data = data_byte;
				taken.row  = row;
				taken.col  = col;
				predict_item(taken);
			end
			in_beat <= push && !full;
			if (pop && !empty) begin
				seen.rs   = rs;
				seen.en   = enable;
				seen.data = data_pins;
				seen.hold = hold_ms;
				seen.err  = error;
				seen.last = last;
				if (expected_events.size() == 0) begin
					fail_count++;
					if (fail_count <= MAX_REPORTS)
						$display("%0t: unexpected beat rs=%0d en=%0d data=%02h hold=%0d err=%0d last=%0d",
							$realtime, seen.rs, seen.en, seen.data, seen.hold, seen.err, seen.last);
				end else begin
					want = expected_events.pop_front();
					if (seen != want) begin
						fail_count++;
						if (fail_count <= MAX_REPORTS) begin
							$display("%0t: mismatch expected rs=%0d en=%0d data=%02h hold=%0d err=%0d last=%0d",
								$realtime, want.rs, want.en, want.data, want.hold, want.err, want.last);
							$display("%0t:            actual rs=%0d en=%0d data=%02h hold=%0d err=%0d last=%0d",
								$realtime, seen.rs, seen.en, seen.data, seen.hold, seen.err, seen.last);
						end
					end
				end
			end
			if (cfg_we || (push && !full) || (pop && !empty))
				idle_cycles = 0;
			else
				idle_cycles++;
			if (idle_cycles >= STALL_LIMIT) begin
				$display("watchdog: no beat for %0d cycles", idle_cycles);
				$display("status: fail");
				$finish;
			end
		end
	end

	// ---------------------------------------------------------------
	// Sender: bursts of items with random gaps between them
	// ---------------------------------------------------------------
	always @(negedge clk) begin : drive_items
		lcd_item_t next_item;
		if (in_beat || !push) begin
			if (gap_left > 0) begin
				gap_left--;
				push <= 1'b0;
			end else if (pending_items.size() != 0) begin
				next_item = pending_items.pop_front();
				func      <= next_item.op;
				data_byte <= next_item.data;
				row       <= next_item.row;
				col       <= next_item.col;
				push      <= 1'b1;
				if (burst_left > 0) burst_left--;
				if (burst_left == 0) begin
					burst_left = $urandom_range(1, 24);
					gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
				end
			end else begin
				push <= 1'b0;
			end
		end
	end

	// ---------------------------------------------------------------
	// Receiver: rotating stall pattern plus an occasional long hold-off
	// ---------------------------------------------------------------
	always @(negedge clk) begin : take_events
		rx_tick++;
		if (hold_served != hold_requests) begin
			hold_served = hold_requests;
			hold_left = LONG_HOLD;
		end
		if (hold_left > 0) begin
			hold_left--;
			pop <= 1'b0;
		end else begin
			// Cycle through free running, coin flips, a fixed pattern and short stalls.
			case ((rx_tick / 150) % 4)
				0:       pop <= 1'b1;
				1:       pop <= ($urandom_range(0, 1) == 1);
				2:       pop <= ((rx_tick % 4) != 0);
				default: pop <= ($urandom_range(0, 9) < 8);
			endcase
		end
	end

	// ---------------------------------------------------------------
	// Stimulus
	// ---------------------------------------------------------------
	function automatic lcd_item_t make_item(input op_t op, input logic [7:0] d,
		input logic [2:0] r, input logic [5:0] c);
		lcd_item_t it;
		it.op   = op;
		it.data = d;
		it.row  = r;
		it.col  = c;
		return it;
	endfunction

	function automatic lcd_item_t rand_item(input int ncols);
		lcd_item_t it;
		int        pick;
		pick    = $urandom_range(0, 99);
		it.data = 8'($urandom_range(0, 255));
		it.row  = 3'($urandom_range(0, 7));
		it.col  = 6'($urandom_range(0, 63));
		if (pick < 5) begin
			it.op = OP_INIT;
		end else if (pick < 30) begin
			it.op = OP_COMMAND;
		end else if (pick < 75) begin
			it.op = OP_CHAR;
		end else begin
			it.op = OP_MOVE;
			if ($urandom_range(0, 9) != 0) it.row = 3'($urandom_range(0, 3));
			// Favor the end of a row so character writes reach the wrap often.
			case ($urandom_range(0, 3))
				0:       it.col = 6'($urandom_range(0, 39));
				1:       it.col = (ncols > 2) ? 6'(ncols - $urandom_range(1, 2)) : 6'd0;
				2:       it.col = 6'd0;
				default: ;
			endcase
		end
		return it;
	endfunction

	task automatic queue_random(input int count);
		repeat (count) pending_items.push_back(rand_item(gen_cols));
	endtask

	task automatic write_reg(input reg_index_t idx, input logic [7:0] value);
		@(negedge clk);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= value;
		@(negedge clk);
		cfg_we <= 1'b0;
	endtask

	task automatic apply_settings(input logic mode, input logic [5:0] ncols,
		input logic [2:0] nrows, input logic [7:0] fs8, input logic [7:0] fs4,
		input logic [7:0] init1, input logic [7:0] init2, input logic [7:0] disp);
		write_reg(REG_FOUR_BIT_MODE, {7'd0, mode});
		write_reg(REG_COLUMN_COUNT, {2'd0, ncols});
		write_reg(REG_ROW_COUNT, {5'd0, nrows});
		write_reg(REG_FUNCTION_SET_EIGHT_BIT, fs8);
		write_reg(REG_FUNCTION_SET_FOUR_BIT, fs4);
		write_reg(REG_FOUR_BIT_INIT_ONE, init1);
		write_reg(REG_FOUR_BIT_INIT_TWO, init2);
		write_reg(REG_DISPLAY_ON_CURSOR_OFF, disp);
		gen_cols = (ncols == 0) ? 1 : ((ncols > DEF_MAX_COLUMNS) ? DEF_MAX_COLUMNS : ncols);
	endtask

	task automatic wait_drained(input int settle);
		while (pending_items.size() != 0 || push || expected_events.size() != 0)
			@(negedge clk);
		repeat (settle) @(negedge clk);
	endtask

	initial begin
		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		repeat (2) @(negedge clk);

		// Register defaults: four-bit bus, 16 columns, 2 rows.
		pending_items.push_back(make_item(OP_INIT, 8'h00, 3'd0, 6'd0));
		pending_items.push_back(make_item(OP_COMMAND, 8'h00, 3'd7, 6'd63));
		pending_items.push_back(make_item(OP_COMMAND, 8'hFF, 3'd0, 6'd0));
		pending_items.push_back(make_item(OP_CHAR, 8'h00, 3'd0, 6'd0));
		pending_items.push_back(make_item(OP_CHAR, 8'hFF, 3'd7, 6'd63));
		pending_items.push_back(make_item(OP_MOVE, 8'h00, 3'd0, 6'd0));
		pending_items.push_back(make_item(OP_MOVE, 8'hFF, 3'd3, 6'd39));
		pending_items.push_back(make_item(OP_MOVE, 8'h00, 3'd4, 6'd0));
		pending_items.push_back(make_item(OP_MOVE, 8'h00, 3'd7, 6'd63));
		pending_items.push_back(make_item(OP_MOVE, 8'h00, 3'd1, 6'd14));
		pending_items.push_back(make_item(OP_CHAR, 8'h41, 3'd0, 6'd0));
		// End of the last row wraps back to row zero.
		pending_items.push_back(make_item(OP_CHAR, 8'h42, 3'd0, 6'd0));
		pending_items.push_back(make_item(OP_MOVE, 8'h00, 3'd0, 6'd15));
		pending_items.push_back(make_item(OP_CHAR, 8'h43, 3'd0, 6'd0));
		// Cursor placed past the column count wraps on the next character.
		pending_items.push_back(make_item(OP_MOVE, 8'h00, 3'd2, 6'd63));
		pending_items.push_back(make_item(OP_CHAR, 8'h5A, 3'd0, 6'd0));
		pending_items.push_back(make_item(OP_MOVE, 8'h00, 3'd1, 6'd32));
		pending_items.push_back(make_item(OP_CHAR, 8'hA5, 3'd0, 6'd0));
		pending_items.push_back(make_item(OP_INIT, 8'hFF, 3'd7, 6'd63));
		// Hold the result side off while the sender keeps offering items.
		hold_requests++;
		queue_random(50);
		wait_drained(8);

		// Eight-bit bus with the smallest display and all-zero commands.
		apply_settings(1'b0, 6'd1, 3'd1, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00);
		queue_random(57);
		wait_drained(8);

		apply_settings(1'b1, 6'd40, 3'd4, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF);
		queue_random(57);
		wait_drained(8);

		// Counts of zero behave as one.
		apply_settings(1'b0, 6'd0, 3'd0, 8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
			8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)));
		queue_random(57);
		wait_drained(8);

		// Counts above the display limits are clamped.
		apply_settings(1'b1, 6'd63, 3'd7, 8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
			8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)));
		queue_random(57);
		wait_drained(8);

		apply_settings(1'($urandom_range(0, 1)), 6'($urandom_range(0, 63)), 3'($urandom_range(0, 7)),
			8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
			8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)));
		queue_random(57);
		wait_drained(8);

		apply_settings(1'b1, 6'd16, 3'd2, 8'h38, 8'h28, 8'h33, 8'h32, 8'h0C);
		queue_random(57);
		wait_drained(20);

		if (expected_events.size() != 0) begin
			$display("%0d expected beats never arrived", expected_events.size());
			fail_count++;
		end
		if (!empty) begin
			$display("result side still holds beats after the last item");
			fail_count++;
		end
		if (fail_count == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end

endmodule
